// ----- hdl/assembly_line_sanitizer_core_assert.svh -----
// Assertion macros shared by the checker of the assembly line sanitizer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSEMBLY_LINE_SANITIZER_CORE_ASSERT_SVH
`define ASSEMBLY_LINE_SANITIZER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASAN_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sanitizer check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define ASAN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sanitizer check failed one cycle later");

`endif

// ----- hdl/asan_pkg.sv -----
// Package of the assembly line sanitizer: byte codes, byte classes, the
// classify function and the result record. Depends on nothing.
package asan_pkg;

    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] PRINT_LO   = 8'h21;
    localparam logic [7:0] PRINT_HI   = 8'h7E;

    localparam int OUT_LEN_W = 9;

    typedef enum logic [2:0] {
        CLS_TERM,
        CLS_SEMI,
        CLS_SPACE,
        CLS_PRINT,
        CLS_DROP
    } byte_class_t;

    typedef struct packed {
        logic                 char_valid;
        logic [6:0]           line_char;
        logic [OUT_LEN_W-1:0] spaces_before;
        logic                 listing_valid;
        logic [7:0]           listing_byte;
        logic                 line_end;
        logic [OUT_LEN_W-1:0] line_length;
        logic                 line_too_long;
    } result_t;

    // Sorts one source byte into the class that decides its handling.
    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t cls;
        if (b == BYTE_NUL || b == BYTE_LF || b == BYTE_CR)
        begin
            cls = CLS_TERM;
        end
        else if (b == BYTE_SEMI)
        begin
            cls = CLS_SEMI;
        end
        else if (b == BYTE_TAB || b == BYTE_SPACE)
        begin
            cls = CLS_SPACE;
        end
        else if (b >= PRINT_LO && b <= PRINT_HI)
        begin
            cls = CLS_PRINT;
        end
        else
        begin
            cls = CLS_DROP;
        end
        return cls;
    endfunction

endpackage

// ----- hdl/asan_line_state.sv -----
// Line state of the assembly line sanitizer: comment and CR flags, the
// saturating length counters and the per-item result logic. Uses asan_pkg.
module asan_line_state #(
    parameter int LINE_LIMIT    = 256,
    parameter int LISTING_LIMIT = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic              accept,
    input  logic [7:0]        raw_byte,
    output asan_pkg::result_t result
);

    localparam int LW = $clog2(LINE_LIMIT + 1);
    localparam int EW = $clog2(LISTING_LIMIT + 1);
    localparam logic [LW-1:0] LINE_MAX    = LW'(LINE_LIMIT);
    localparam logic [LW-1:0] LINE_NEAR   = LW'(LINE_LIMIT - 1);
    localparam logic [EW-1:0] LISTING_MAX = EW'(LISTING_LIMIT);
    localparam int OUT_W_PAD = asan_pkg::OUT_LEN_W;

    logic          listing_on_reg;
    logic          in_comment_reg, in_comment_next;
    logic          swallow_lf_reg, swallow_lf_next;
    logic [LW-1:0] held_reg, held_next;
    logic [LW-1:0] kept_reg, kept_next;
    logic [LW-1:0] total_reg, total_next;
    logic [EW-1:0] echo_reg, echo_next;

    logic [LW-1:0] held_inc;
    logic [LW-1:0] total_inc;
    logic [EW-1:0] echo_inc;
    logic [LW+OUT_W_PAD-1:0] held_ext;
    logic [LW+OUT_W_PAD-1:0] kept_ext;
    asan_pkg::byte_class_t cls;

    assign held_inc  = (held_reg < LINE_MAX) ? held_reg + 1'b1 : LINE_MAX;
    assign total_inc = (total_reg < LINE_MAX) ? total_reg + 1'b1 : LINE_MAX;
    assign echo_inc  = (echo_reg < LISTING_MAX) ? echo_reg + 1'b1 : LISTING_MAX;
    // Zero-extended copies so the 9-bit output view works for any counter width.
    assign held_ext  = {{OUT_W_PAD{1'b0}}, held_reg};
    assign kept_ext  = {{OUT_W_PAD{1'b0}}, kept_reg};
    assign cls       = asan_pkg::classify(raw_byte);

    always_comb
    begin
        result          = '0;
        in_comment_next = in_comment_reg;
        swallow_lf_next = 1'b0;
        held_next       = held_reg;
        kept_next       = kept_reg;
        total_next      = total_reg;
        echo_next       = echo_reg;

        if (swallow_lf_reg && raw_byte == asan_pkg::BYTE_LF)
        begin
            // LF right after a CR line end: nothing at all.
            result = '0;
        end
        else if (cls == asan_pkg::CLS_TERM)
        begin
            result.line_end    = 1'b1;
            result.line_length = kept_ext[asan_pkg::OUT_LEN_W-1:0];
            result.line_too_long = listing_on_reg ? (echo_reg >= LISTING_MAX)
                                                  : (total_reg >= LINE_NEAR);
            in_comment_next = 1'b0;
            held_next       = '0;
            kept_next       = '0;
            total_next      = '0;
            echo_next       = '0;
            swallow_lf_next = (raw_byte == asan_pkg::BYTE_CR);
        end
        else
        begin
            result.listing_valid = 1'b1;
            result.listing_byte  = raw_byte;
            echo_next            = echo_inc;
            if (!in_comment_reg)
            begin
                case (cls)
                    asan_pkg::CLS_SEMI:
                    begin
                        in_comment_next = 1'b1;
                    end
                    asan_pkg::CLS_SPACE:
                    begin
                        held_next  = held_inc;
                        total_next = total_inc;
                    end
                    asan_pkg::CLS_PRINT:
                    begin
                        result.char_valid    = 1'b1;
                        result.line_char     = raw_byte[6:0];
                        result.spaces_before = held_ext[asan_pkg::OUT_LEN_W-1:0];
                        held_next            = '0;
                        total_next           = total_inc;
                        kept_next            = total_inc;
                    end
                    default:
                    begin
                        // Dropped bytes are only echoed.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listing_on_reg <= 1'b0;
            in_comment_reg <= 1'b0;
            swallow_lf_reg <= 1'b0;
            held_reg       <= '0;
            kept_reg       <= '0;
            total_reg      <= '0;
            echo_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                listing_on_reg <= cfg_data;
            end
            if (accept)
            begin
                in_comment_reg <= in_comment_next;
                swallow_lf_reg <= swallow_lf_next;
                held_reg       <= held_next;
                kept_reg       <= kept_next;
                total_reg      <= total_next;
                echo_reg       <= echo_next;
            end
        end
    end

endmodule

// ----- hdl/asan_out_reg.sv -----
// Result register of the assembly line sanitizer with valid/stall output
// handshake. Uses asan_pkg for the result record.
module asan_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  asan_pkg::result_t load_data,
    input  logic              res_stall,
    output logic              res_valid,
    output asan_pkg::result_t res_data
);

    logic              valid_reg;
    asan_pkg::result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

// ----- hdl/assembly_line_sanitizer_core.sv -----
// Assembly line sanitizer, top level. Uses asan_pkg, asan_line_state, asan_out_reg.
// The result of an item is registered and shown in the cycle after the item is accepted.
// Throughput: one item per cycle; the only limit is the single result register,
// which takes a new item whenever it is empty or being drained in the same cycle.
// Reset (rst_n low, asynchronous) clears listing_on, all line state and the
// result valid; no clearing pass is needed.
module assembly_line_sanitizer_core #(
    parameter int LINE_LIMIT    = 256,
    parameter int LISTING_LIMIT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration: one register, listing_on.
    input  logic       cfg_we,
    input  logic       cfg_data,
    // Source byte channel.
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] raw_byte,
    // Result channel.
    output logic       res_valid,
    input  logic       res_stall,
    output logic       char_valid,
    output logic [6:0] line_char,
    output logic [8:0] spaces_before,
    output logic       listing_valid,
    output logic [7:0] listing_byte,
    output logic       line_end,
    output logic [8:0] line_length,
    output logic       line_too_long
);

    logic              accept;
    asan_pkg::result_t step_result;
    asan_pkg::result_t res_data;

    // The source is held off only while a finished result waits and the
    // consumer stalls it; otherwise the register is free or drains this cycle.
    assign src_stall = res_valid && res_stall;
    assign accept    = src_valid && !src_stall;

    // All per-byte work happens in the line state logic: the byte class picks
    // one of the swallowed-LF, line-end, comment, space, kept or dropped paths, and
    // the flags and saturating counters advance only on an accepted item.
    asan_line_state #(
        .LINE_LIMIT    (LINE_LIMIT),
        .LISTING_LIMIT (LISTING_LIMIT)
    ) u_line_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .raw_byte (raw_byte),
        .result   (step_result)
    );

    // The result register parts the two channels; the source is held off
    // while a result waits on a stalled consumer.
    asan_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (step_result),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    assign char_valid    = res_data.char_valid;
    assign line_char     = res_data.line_char;
    assign spaces_before = res_data.spaces_before;
    assign listing_valid = res_data.listing_valid;
    assign listing_byte  = res_data.listing_byte;
    assign line_end      = res_data.line_end;
    assign line_length   = res_data.line_length;
    assign line_too_long = res_data.line_too_long;

endmodule

// ----- hdl/asan_checker.sv -----
// Port-level checker of the assembly line sanitizer and its bind statement.
// Uses the macros of assembly_line_sanitizer_core_assert.svh.
`include "assembly_line_sanitizer_core_assert.svh"

module asan_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       src_valid,
    input logic       src_stall,
    input logic       res_valid,
    input logic       res_stall,
    input logic       char_valid,
    input logic [6:0] line_char,
    input logic       listing_valid,
    input logic       line_end
);

    // A stalled result stays offered.
    `ASAN_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
    // Every accepted item produces a result in the next cycle.
    `ASAN_ASSERT_NEXT(a_item_to_result, src_valid && !src_stall, res_valid)
    // A kept character is always echoed and never ends a line.
    `ASAN_ASSERT_SAME(a_char_echoed, res_valid && char_valid,
        listing_valid && !line_end)
    // A line end is never echoed.
    `ASAN_ASSERT_SAME(a_end_silent, res_valid && line_end,
        !listing_valid && !char_valid)
    // Kept characters are printable and never the comment mark.
    `ASAN_ASSERT_SAME(a_char_printable, res_valid && char_valid,
        line_char >= 7'h21 && line_char <= 7'h7E && line_char != 7'h3B)

endmodule

bind assembly_line_sanitizer_core asan_checker u_asan_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .src_valid     (src_valid),
    .src_stall     (src_stall),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .char_valid    (char_valid),
    .line_char     (line_char),
    .listing_valid (listing_valid),
    .line_end      (line_end)
);
